// ===== rtl/synaptic_current_row_accumulator_assert.svh =====
// Assertion macros for the row accumulator
`ifndef SYNAPTIC_CURRENT_ROW_ACCUMULATOR_ASSERT_SVH
`define SYNAPTIC_CURRENT_ROW_ACCUMULATOR_ASSERT_SVH

// Check cons in the same cycle as ante
`define SCRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante
`define SCRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/scra_pkg.sv =====
`timescale 1ns / 1ps

package scra_pkg;

	localparam int WEIGHT_W = 16;
	localparam int VALUE_W = 16;
	localparam int CURRENT_W = 32;
	localparam int PROD_W = WEIGHT_W + VALUE_W;
	localparam int WSUM_W = 48;
	localparam int WTOT_W = 32;
	localparam int GAP_W = VALUE_W + WTOT_W;
	localparam int ACC_W = 50;
	localparam int RES_W = ACC_W + 1;

	localparam int IN_DATA_W = 80;
	localparam int WEIGHT_LSB = 0;
	localparam int SOURCE_LSB = 16;
	localparam int TARGET_LSB = 32;
	localparam int PRIOR_LSB = 48;
	localparam int OUT_DATA_W = 32;

	localparam int DEF_WEIGHT_FRAC_BITS = 14;

	typedef enum logic {
		MODE_SPIKE = 1'b0,
		MODE_GAP   = 1'b1
	} mode_t;

endpackage

// ===== rtl/synaptic_current_row_accumulator.sv =====
`timescale 1ns / 1ps

// A row's last beat passes through stages s1 to s5 and the output register before it appears on the output.
// Throughput: one input beat per cycle while the output is not stalled; one multiply-accumulate per beat.
// Input beats keep flowing while a result waits, until the pipeline fills.
// Reset (arst_n low, asynchronous): sums cleared, mode set to spike, pipeline empty.
module synaptic_current_row_accumulator #(
	parameter int WEIGHT_FRAC_BITS = scra_pkg::DEF_WEIGHT_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// weight[15:0], source_value[31:16], target_voltage[47:32], prior_current[79:48]
	input  logic [scra_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// new_current[31:0]
	output logic [scra_pkg::OUT_DATA_W-1:0]   m_tdata,
	// saturated[0]
	output logic                              m_tuser
);

	localparam int WW = scra_pkg::WEIGHT_W;
	localparam int VW = scra_pkg::VALUE_W;
	localparam int CW = scra_pkg::CURRENT_W;
	localparam int PW = scra_pkg::PROD_W;
	localparam int SW = scra_pkg::WSUM_W;
	localparam int TW = scra_pkg::WTOT_W;
	localparam int GW = scra_pkg::GAP_W;
	localparam int AW = scra_pkg::ACC_W;
	localparam int RW = scra_pkg::RES_W;
	localparam logic [AW-1:0] HALF = AW'(1) << (WEIGHT_FRAC_BITS - 1);

	scra_pkg::mode_t mode_q;
	logic signed [SW-1:0] ws_q;
	logic signed [TW-1:0] wt_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

	logic signed [WW-1:0] w_s1;
	logic signed [VW-1:0] src_s1;
	logic signed [VW-1:0] vt_s1;
	logic signed [CW-1:0] prior_s1;
	logic                 last_s1;

	logic signed [PW-1:0] prod_s2;
	logic signed [WW-1:0] w_s2;
	logic signed [VW-1:0] vt_s2;
	logic signed [CW-1:0] prior_s2;
	logic                 last_s2;

	logic signed [SW-1:0] ws_s3;
	logic signed [TW-1:0] wt_s3;
	logic signed [VW-1:0] vt_s3;
	logic signed [CW-1:0] prior_s3;

	logic signed [SW-1:0] ws_s4;
	logic signed [GW-1:0] gp_s4;
	logic signed [CW-1:0] prior_s4;

	logic [AW-1:0]        acc_s5;
	logic signed [CW-1:0] prior_s5;

	logic [CW-1:0] cur_q;
	logic          sat_q;

	logic signed [PW-1:0] prod;
	logic signed [SW-1:0] ws_nxt;
	logic signed [TW-1:0] wt_nxt;
	logic signed [GW-1:0] gap_prod;
	logic signed [GW-1:0] gp;
	logic [AW-1:0]        acc;
	logic signed [AW-1:0] shifted;
	logic [RW-1:0]        res;
	logic                 sat_hi, sat_lo;

	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy5     = !v5_s5 || rdy_out;
	assign rdy4     = !v4_s4 || rdy5;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || !last_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign s_tready = rdy1;

	assign prod     = w_s1 * src_s1;
	assign ws_nxt   = ws_q + {{(SW-PW){prod_s2[PW-1]}}, prod_s2};
	assign wt_nxt   = wt_q + {{(TW-WW){w_s2[WW-1]}}, w_s2};
	assign gap_prod = vt_s3 * wt_s3;
	assign gp       = (mode_q == scra_pkg::MODE_GAP) ? gap_prod : '0;
	assign acc    = {{(AW-SW){ws_s4[SW-1]}}, ws_s4} - {{(AW-GW){gp_s4[GW-1]}}, gp_s4} + HALF;

	assign shifted = $signed(acc_s5) >>> WEIGHT_FRAC_BITS;
	assign res     = {shifted[AW-1], shifted} + {{(RW-CW){prior_s5[CW-1]}}, prior_s5};
	assign sat_hi  = !res[RW-1] && (|res[RW-2:CW-1]);
	assign sat_lo  = res[RW-1] && !(&res[RW-2:CW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= scra_pkg::MODE_SPIKE;
			ws_q        <= '0;
			wt_q        <= '0;
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			v5_s5       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= scra_pkg::mode_t'(cfg_wdata);
			end
			if (rdy1) begin
				v1_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (v2_s2 && (!last_s2 || rdy3)) begin
				if (last_s2) begin
					ws_q <= '0;
					wt_q <= '0;
				end else begin
					ws_q <= ws_nxt;
					wt_q <= wt_nxt;
				end
			end
			if (rdy3) begin
				v3_s3 <= v2_s2 && last_s2;
			end
			if (rdy4) begin
				v4_s4 <= v3_s3;
			end
			if (rdy5) begin
				v5_s5 <= v4_s4;
			end
			if (rdy_out) begin
				out_valid_q <= v5_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			w_s1     <= s_tdata[scra_pkg::WEIGHT_LSB +: WW];
			src_s1   <= s_tdata[scra_pkg::SOURCE_LSB +: VW];
			vt_s1    <= s_tdata[scra_pkg::TARGET_LSB +: VW];
			prior_s1 <= s_tdata[scra_pkg::PRIOR_LSB +: CW];
			last_s1  <= s_tlast;
		end
		if (v1_s1 && rdy2) begin
			prod_s2  <= prod;
			w_s2     <= w_s1;
			vt_s2    <= vt_s1;
			prior_s2 <= prior_s1;
			last_s2  <= last_s1;
		end
		if (v2_s2 && last_s2 && rdy3) begin
			ws_s3    <= ws_nxt;
			wt_s3    <= wt_nxt;
			vt_s3    <= vt_s2;
			prior_s3 <= prior_s2;
		end
		if (v3_s3 && rdy4) begin
			ws_s4    <= ws_s3;
			gp_s4    <= gp;
			prior_s4 <= prior_s3;
		end
		if (v4_s4 && rdy5) begin
			acc_s5   <= acc;
			prior_s5 <= prior_s4;
		end
		if (v5_s5 && rdy_out) begin
			sat_q <= sat_hi || sat_lo;
			if (sat_hi) begin
				cur_q <= {1'b0, {(CW-1){1'b1}}};
			end else if (sat_lo) begin
				cur_q <= {1'b1, {(CW-1){1'b0}}};
			end else begin
				cur_q <= res[CW-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = cur_q;
	assign m_tuser  = sat_q;

`include "synaptic_current_row_accumulator_assert.svh"

	`SCRA_ASSERT_NEXT(a_row_clears_sums, v2_s2 && last_s2 && rdy3, ws_q == '0 && wt_q == '0, "sums not cleared after row end")
	`SCRA_ASSERT_NEXT(a_result_reaches_out, v5_s5 && rdy_out, m_tvalid, "result lost between final stage and output")
	`SCRA_ASSERT_NOW(a_stall_only_when_full, !s_tready, v1_s1 && v2_s2 && last_s2 && v3_s3 && v4_s4 && v5_s5 && m_tvalid && !m_tready, "input stalled with room in pipeline")

endmodule
